// ===== rtl/mmvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmvd_pkg;

  localparam int IDX_BITS   = 3;
  localparam int LEN_BITS   = 5;
  localparam int R_BITS     = 4;
  localparam int FCODE_BITS = 4;
  localparam int RES_BITS   = 8;
  localparam int MAG_BITS   = 5;
  localparam int VLEN_BITS  = 4;
  localparam int DMAG_BITS  = 13;
  localparam int DELTA_BITS = DMAG_BITS + 1;
  localparam int DM_BITS    = 2;
  localparam int MAX_BITS_USED = 21;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [FCODE_BITS-1:0] FCODE_MIN = 4'd1;
  localparam logic [FCODE_BITS-1:0] FCODE_MAX = 4'd9;

  typedef struct packed {
    logic                 err;
    logic [MAG_BITS-1:0]  mag;
    logic [VLEN_BITS-1:0] len;
  } mcode_t;

  typedef struct packed {
    logic                         clear;
    logic                         err;
    logic [IDX_BITS-1:0]          idx;
    logic                         full_pel;
    logic [R_BITS-1:0]            r_size;
    logic signed [DELTA_BITS-1:0] delta;
    logic [LEN_BITS-1:0]          bits_used;
    logic signed [DM_BITS-1:0]    dm;
  } parse_t;

  typedef struct packed {
    logic                wr_en;
    logic                clr;
    logic [IDX_BITS-1:0] idx;
  } wr_ctl_t;

  function automatic logic [R_BITS-1:0] fcode_to_rsize(input logic [FCODE_BITS-1:0] f);
    logic [FCODE_BITS-1:0] fc;
    fc = f;
    if (fc < FCODE_MIN) fc = FCODE_MIN;
    if (fc > FCODE_MAX) fc = FCODE_MAX;
    return R_BITS'(fc - FCODE_MIN);
  endfunction

  // motion code magnitude and code length after a leading zero
  function automatic mcode_t mcode_lookup(input logic [8:0] p9);
    mcode_t v;
    v = '0;
    priority if (p9 >= 9'd64) begin
      unique case (p9[8:6])
        3'd0: begin v.mag = 5'd0; v.len = 4'd1; end
        3'd1: begin v.mag = 5'd3; v.len = 4'd4; end
        3'd2, 3'd3: begin v.mag = 5'd2; v.len = 4'd3; end
        default: begin v.mag = 5'd1; v.len = 4'd2; end
      endcase
    end else if (p9 >= 9'd24) begin
      unique case (p9[5:3])
        3'd3: begin v.mag = 5'd7; v.len = 4'd7; end
        3'd4: begin v.mag = 5'd6; v.len = 4'd7; end
        3'd5: begin v.mag = 5'd5; v.len = 4'd7; end
        3'd6, 3'd7: begin v.mag = 5'd4; v.len = 4'd6; end
        default: begin v.mag = 5'd0; v.len = 4'd1; end
      endcase
    end else if (p9 >= 9'd12) begin
      unique case (p9[4:0])
        5'd12: begin v.mag = 5'd16; v.len = 4'd10; end
        5'd13: begin v.mag = 5'd15; v.len = 4'd10; end
        5'd14: begin v.mag = 5'd14; v.len = 4'd10; end
        5'd15: begin v.mag = 5'd13; v.len = 4'd10; end
        5'd16: begin v.mag = 5'd12; v.len = 4'd10; end
        5'd17: begin v.mag = 5'd11; v.len = 4'd10; end
        5'd18, 5'd19: begin v.mag = 5'd10; v.len = 4'd9; end
        5'd20, 5'd21: begin v.mag = 5'd9; v.len = 4'd9; end
        5'd22, 5'd23: begin v.mag = 5'd8; v.len = 4'd9; end
        default: begin v.mag = 5'd0; v.len = 4'd1; end
      endcase
    end else begin
      v.err = 1'b1;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mmvd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmvd_parse #(
  parameter int WINDOW_BITS = 24
) (
  input  wire logic                                opcode,
  input  wire logic [WINDOW_BITS-1:0]              bit_window,
  input  wire logic                                direction,
  input  wire logic                                vector_slot,
  input  wire logic                                component,
  input  wire logic                                full_pel,
  input  wire logic                                dual_prime,
  input  wire logic [mmvd_pkg::FCODE_BITS-1:0]     fcode,
  output mmvd_pkg::parse_t                         result
);

  localparam int LB = mmvd_pkg::LEN_BITS;
  localparam logic [mmvd_pkg::R_BITS-1:0] R_BITS_8 = mmvd_pkg::R_BITS'(mmvd_pkg::RES_BITS);

  mmvd_pkg::mcode_t                     mcode;
  logic [mmvd_pkg::R_BITS-1:0]          r_size;
  logic [mmvd_pkg::MAG_BITS-1:0]        mag;
  logic [LB-1:0]                        len_sign;
  logic [LB-1:0]                        len_res;
  logic [LB-1:0]                        len_dm;
  logic [LB-1:0]                        len_total;
  logic [WINDOW_BITS-1:0]               sh_sign;
  logic [WINDOW_BITS-1:0]               sh_res;
  logic [WINDOW_BITS-1:0]               sh_dm;
  logic [mmvd_pkg::RES_BITS-1:0]        res_top;
  logic [mmvd_pkg::RES_BITS-1:0]        res;
  logic                                 neg;
  logic                                 has_res;
  logic [mmvd_pkg::DMAG_BITS-1:0]       dmag;
  logic signed [mmvd_pkg::DELTA_BITS-1:0] delta;
  logic signed [mmvd_pkg::DM_BITS-1:0]  dm;

  always_comb begin
    r_size = mmvd_pkg::fcode_to_rsize(fcode);
    mcode  = mmvd_pkg::mcode_lookup(bit_window[WINDOW_BITS-2 -: 9]);

    // leading one is motion code zero with no sign bit
    if (bit_window[WINDOW_BITS-1]) begin
      mag      = '0;
      len_sign = LB'(1);
    end else begin
      mag      = mcode.mag;
      len_sign = LB'(mcode.len) + LB'(1);
    end

    sh_sign = bit_window << LB'(mcode.len);
    neg     = !bit_window[WINDOW_BITS-1] && sh_sign[WINDOW_BITS-1];

    has_res = (mag != '0) && (r_size != '0);
    sh_res  = bit_window << len_sign;
    res_top = sh_res[WINDOW_BITS-1 -: mmvd_pkg::RES_BITS];
    res     = has_res ? (res_top >> (R_BITS_8 - r_size)) : '0;
    len_res = has_res ? (len_sign + LB'(r_size)) : len_sign;

    sh_dm  = bit_window << len_res;
    dm     = '0;
    len_dm = len_res;
    if (dual_prime) begin
      if (sh_dm[WINDOW_BITS-1]) begin
        dm     = sh_dm[WINDOW_BITS-2] ? -2'sd1 : 2'sd1;
        len_dm = len_res + LB'(2);
      end else begin
        len_dm = len_res + LB'(1);
      end
    end
    len_total = len_dm;

    dmag  = (mmvd_pkg::DMAG_BITS'(mag - mmvd_pkg::MAG_BITS'(1)) << r_size)
            + mmvd_pkg::DMAG_BITS'(res) + mmvd_pkg::DMAG_BITS'(1);
    delta = '0;
    if (mag != '0) begin
      delta = neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    end

    result           = '0;
    result.idx       = {vector_slot, direction, component};
    result.full_pel  = full_pel;
    result.r_size    = r_size;
    if (opcode == mmvd_pkg::OP_CLEAR) begin
      result.clear = 1'b1;
    end else if (!bit_window[WINDOW_BITS-1] && mcode.err) begin
      result.err = 1'b1;
    end else begin
      result.delta     = delta;
      result.bits_used = len_total;
      result.dm        = dm;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmvd_pred_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmvd_pred_store #(
  parameter int PRED_BITS = 13
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              rd_en,
  input  wire logic [mmvd_pkg::IDX_BITS-1:0]     rd_idx,
  input  wire mmvd_pkg::wr_ctl_t                 wr,
  input  wire logic signed [PRED_BITS-1:0]       wr_data,
  output logic signed [PRED_BITS-1:0]            pred
);

  localparam int DEPTH = 1 << mmvd_pkg::IDX_BITS;

  logic signed [PRED_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;
  logic signed [PRED_BITS-1:0] rd_q;
  logic                        rd_valid_q;
  logic                        fwd_q;
  logic                        clr_q;
  logic signed [PRED_BITS-1:0] fwd_data_q;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem[rd_idx];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      clr_q      <= 1'b0;
    end else begin
      if (wr.clr) begin
        valid <= '0;
      end else if (wr.wr_en) begin
        valid[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid[rd_idx];
        fwd_q      <= wr.wr_en && (wr.idx == rd_idx);
        clr_q      <= wr.clr;
      end
    end
  end

  // write landing in the read cycle is forwarded, unwritten entries read zero
  always_comb begin
    priority if (clr_q) begin
      pred = '0;
    end else if (fwd_q) begin
      pred = fwd_data_q;
    end else if (rd_valid_q) begin
      pred = rd_q;
    end else begin
      pred = '0;
    end
  end

  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr.wr_en && wr.clr))
    else $error("predictor write and clear together");

  a_wr_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr.wr_en |=> valid[$past(wr.idx)])
    else $error("written predictor not marked valid");

endmodule

`default_nettype wire

// ===== rtl/mpeg_motion_vector_decode_core.sv =====
// Decodes one MPEG-2 motion vector component per item and keeps the eight predictors
// (slot, direction, component) in a small synchronous memory. Sustained rate is one
// item per cycle while m_tready stays high; an item's result is registered in s1 and
// then in the output register. The accept cycle parses the motion code, residual and
// dual-prime bits and issues the predictor read; the s1 stage then rebuilds, wraps and
// scales the vector and writes it back when it advances, with the write forwarded to
// a read of the same entry issued in that cycle. The clear opcode resets all predictors
// at once through per-entry valid bits. Configuration registers are f_code values
// selected by direction and component; write them only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_motion_vector_decode_core #(
  parameter int WINDOW_BITS = 24,
  parameter int PRED_BITS   = 13
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // bit_window, direction, vector_slot, component, full_pel, dual_prime
  input  wire logic [((WINDOW_BITS + 5 + 7) / 8) * 8 - 1:0] s_tdata,
  // opcode
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // vector_value, bits_used, dm_value
  output logic [((PRED_BITS + mmvd_pkg::LEN_BITS + mmvd_pkg::DM_BITS + 7) / 8) * 8 - 1:0]
                                    m_tdata,
  // code_error
  output logic                      m_tuser,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [mmvd_pkg::FCODE_BITS-1:0] cfg_data
);

  localparam int OUT_BITS = PRED_BITS + mmvd_pkg::LEN_BITS + mmvd_pkg::DM_BITS;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int SW    = PRED_BITS + 2;
  localparam int SW_IDX_BITS = $clog2(SW);

  localparam logic [1:0] REG_FCODE_FWD_HORIZ = 2'd0;
  localparam logic [1:0] REG_FCODE_FWD_VERT  = 2'd1;
  localparam logic [1:0] REG_FCODE_BWD_HORIZ = 2'd2;
  localparam logic [1:0] REG_FCODE_BWD_VERT  = 2'd3;

  logic [mmvd_pkg::FCODE_BITS-1:0] fcode_fwd_horiz;
  logic [mmvd_pkg::FCODE_BITS-1:0] fcode_fwd_vert;
  logic [mmvd_pkg::FCODE_BITS-1:0] fcode_bwd_horiz;
  logic [mmvd_pkg::FCODE_BITS-1:0] fcode_bwd_vert;
  logic [mmvd_pkg::FCODE_BITS-1:0] fcode_sel;

  logic [WINDOW_BITS-1:0] in_window;
  logic                   in_dir;
  logic                   in_slot;
  logic                   in_comp;
  logic                   in_fp;
  logic                   in_dp;

  logic              s_accept;
  logic              s1_valid;
  logic              s1_advance;
  mmvd_pkg::parse_t  parse_out;
  mmvd_pkg::parse_t  s1;
  mmvd_pkg::wr_ctl_t wr;

  logic signed [PRED_BITS-1:0] pred;
  logic signed [PRED_BITS-1:0] base;
  logic signed [SW-1:0]        sum;
  logic signed [SW-1:0]        wrapped;
  logic signed [SW-1:0]        scaled;
  logic [SW_IDX_BITS-1:0]      sign_pos;
  logic signed [PRED_BITS-1:0] vec;
  logic signed [PRED_BITS-1:0] vec_out;

  logic signed [PRED_BITS-1:0]         out_vec;
  logic [mmvd_pkg::LEN_BITS-1:0]       out_bits;
  logic signed [mmvd_pkg::DM_BITS-1:0] out_dm;
  logic                                out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcode_fwd_horiz <= mmvd_pkg::FCODE_MIN;
      fcode_fwd_vert  <= mmvd_pkg::FCODE_MIN;
      fcode_bwd_horiz <= mmvd_pkg::FCODE_MIN;
      fcode_bwd_vert  <= mmvd_pkg::FCODE_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FCODE_FWD_HORIZ: fcode_fwd_horiz <= cfg_data;
        REG_FCODE_FWD_VERT:  fcode_fwd_vert  <= cfg_data;
        REG_FCODE_BWD_HORIZ: fcode_bwd_horiz <= cfg_data;
        REG_FCODE_BWD_VERT:  fcode_bwd_vert  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_window = s_tdata[WINDOW_BITS-1:0];
  assign in_dir    = s_tdata[WINDOW_BITS];
  assign in_slot   = s_tdata[WINDOW_BITS+1];
  assign in_comp   = s_tdata[WINDOW_BITS+2];
  assign in_fp     = s_tdata[WINDOW_BITS+3];
  assign in_dp     = s_tdata[WINDOW_BITS+4];

  always_comb begin
    unique case ({in_dir, in_comp})
      REG_FCODE_FWD_HORIZ: fcode_sel = fcode_fwd_horiz;
      REG_FCODE_FWD_VERT:  fcode_sel = fcode_fwd_vert;
      REG_FCODE_BWD_HORIZ: fcode_sel = fcode_bwd_horiz;
      default:             fcode_sel = fcode_bwd_vert;
    endcase
  end

  mmvd_parse #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_parse (
    .opcode     (s_tuser),
    .bit_window (in_window),
    .direction  (in_dir),
    .vector_slot(in_slot),
    .component  (in_comp),
    .full_pel   (in_fp),
    .dual_prime (in_dp),
    .fcode      (fcode_sel),
    .result     (parse_out)
  );

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign s_accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1 <= parse_out;
    end
  end

  always_comb begin
    wr.wr_en = s1_advance && !s1.clear && !s1.err;
    wr.clr   = s1_advance && s1.clear;
    wr.idx   = s1.idx;
  end

  mmvd_pred_store #(
    .PRED_BITS(PRED_BITS)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (s_accept),
    .rd_idx (parse_out.idx),
    .wr     (wr),
    .wr_data(vec),
    .pred   (pred)
  );

  // rebuild, wrap into 32 << r_size and apply full-pel scaling
  always_comb begin
    base     = s1.full_pel ? (pred >>> 1) : pred;
    sum      = SW'(base) + SW'(s1.delta);
    sign_pos = SW_IDX_BITS'(s1.r_size) + SW_IDX_BITS'(4);
    for (int i = 0; i < SW; i++) begin
      wrapped[i] = (SW_IDX_BITS'(i) <= sign_pos) ? sum[i] : sum[sign_pos];
    end
    scaled = wrapped << s1.full_pel;
    vec    = scaled[PRED_BITS-1:0];
    priority if (s1.clear) begin
      vec_out = '0;
    end else if (s1.err) begin
      vec_out = pred;
    end else begin
      vec_out = vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_vec  <= vec_out;
      out_bits <= s1.bits_used;
      out_dm   <= s1.dm;
      out_err  <= s1.err;
    end
  end

  assign m_tdata = OUT_W'({out_dm, out_bits, out_vec});
  assign m_tuser = out_err;

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_err) |-> (out_bits == '0 && out_dm == '0))
    else $error("invalid code item carries length or dm");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1.clear) |=> (m_tdata == '0 && !m_tuser))
    else $error("clear item result not zero");

  a_bits_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_bits <= mmvd_pkg::LEN_BITS'(mmvd_pkg::MAX_BITS_USED) && out_dm != 2'b10))
    else $error("bits_used or dm out of range");

endmodule

`default_nettype wire
